### src/fir_pkg.sv
// Shared constants, types and helpers of the streaming FIR filter.
package fir_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_TAPS_DEF       = 64;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int COEF_BITS       = 18;
    localparam int TAP_COUNT_BITS  = 7;
    localparam int COEF_INDEX_BITS = 6;

    // Sample bits consumed by the multiply-accumulate in each cycle.
    localparam int DIGIT_BITS = 8;

    // Request type codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    // Control from the sequencer to the digit-serial multiply-accumulate.
    typedef struct packed {
        logic active;
        logic first_digit;
        logic last_digit;
        logic clear_acc;
    } mac_ctrl_t;

    // Number of digits that a sample of the given width is split into.
    function automatic int digit_count(input int bits);
        return (bits + DIGIT_BITS - 1) / DIGIT_BITS;
    endfunction

endpackage

### src/fir_coef_mem.sv
// Coefficient store: one write port and one registered read port.
module fir_coef_mem #(
    parameter int MAX_TAPS  = fir_pkg::MAX_TAPS_DEF,
    parameter int ADDR_BITS = 6
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [ADDR_BITS-1:0]                wr_addr,
    input  logic signed [fir_pkg::COEF_BITS-1:0] wr_data,
    input  logic                                rd_en,
    input  logic [ADDR_BITS-1:0]                rd_addr,
    output logic signed [fir_pkg::COEF_BITS-1:0] rd_data
);
    import fir_pkg::*;

    logic signed [COEF_BITS-1:0] mem [MAX_TAPS];
    logic signed [COEF_BITS-1:0] rd_data_reg;

    // Write and registered read of the store.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/fir_hist_line.sv
// Sample history held as a circular buffer with a fill count per record.
module fir_hist_line #(
    parameter int MAX_TAPS    = fir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_BITS   = 6,
    parameter int FILL_BITS   = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          block_start,
    input  logic signed [SAMPLE_BITS-1:0] wr_data,
    input  logic                          rd_en,
    output logic signed [SAMPLE_BITS-1:0] rd_data,
    output logic [FILL_BITS-1:0]          fill
);
    import fir_pkg::*;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0]          wptr_reg;
    logic [ADDR_BITS-1:0]          wptr_next;
    logic [ADDR_BITS-1:0]          rptr_reg;
    logic [ADDR_BITS-1:0]          rptr_dec;
    logic [FILL_BITS-1:0]          fill_reg;

    // Pointer arithmetic with wrap at the depth of the line.
    always_comb
    begin
        if (wptr_reg == ADDR_BITS'(MAX_TAPS - 1))
        begin
            wptr_next = '0;
        end
        else
        begin
            wptr_next = wptr_reg + ADDR_BITS'(1);
        end
        if (rptr_reg == '0)
        begin
            rptr_dec = ADDR_BITS'(MAX_TAPS - 1);
        end
        else
        begin
            rptr_dec = rptr_reg - ADDR_BITS'(1);
        end
    end

    // Pointers and fill count. Entries older than the fill count count as zero,
    // so a record start only has to reset the count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else if (wr_en)
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= wptr_next;
            if (block_start)
            begin
                fill_reg <= FILL_BITS'(1);
            end
            else if (fill_reg != FILL_BITS'(MAX_TAPS))
            begin
                fill_reg <= fill_reg + FILL_BITS'(1);
            end
        end
        else if (rd_en)
        begin
            rptr_reg <= rptr_dec;
        end
    end

    // Sample memory: the newest sample goes in, reads walk back in time.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_next] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rptr_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule

### src/fir_digit_mac.sv
// Digit-serial multiply-accumulate: one sample digit per cycle, most significant first.
module fir_digit_mac #(
    parameter int SAMPLE_BITS = fir_pkg::SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = 48
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fir_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [fir_pkg::COEF_BITS-1:0] coef_rd,
    input  logic signed [SAMPLE_BITS-1:0]        samp_rd,
    output logic signed [ACC_BITS-1:0]           acc
);
    import fir_pkg::*;

    localparam int NDIG   = digit_count(SAMPLE_BITS);
    localparam int SR_W   = NDIG * DIGIT_BITS;
    localparam int PROD_W = COEF_BITS + DIGIT_BITS + 1;
    localparam int TAP_W  = COEF_BITS + SR_W;

    logic signed [SR_W-1:0]       samp_ext;
    logic signed [SR_W-1:0]       sr_src;
    logic signed [SR_W-1:0]       sr_reg;
    logic [DIGIT_BITS-1:0]        digit_raw;
    logic signed [DIGIT_BITS:0]   digit_s;
    logic signed [COEF_BITS-1:0]  coef_cur;
    logic signed [COEF_BITS-1:0]  coef_reg;
    logic signed [PROD_W-1:0]     prod;
    logic signed [TAP_W-1:0]      tap_next;
    logic signed [TAP_W-1:0]      tap_acc_reg;
    logic                         tap_done_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;

    // Operand selection: the first digit of a tap comes straight from the read ports.
    assign samp_ext  = SR_W'(samp_rd);
    assign sr_src    = ctrl.first_digit ? samp_ext : sr_reg;
    assign coef_cur  = ctrl.first_digit ? coef_rd : coef_reg;
    assign digit_raw = sr_src[SR_W-1 -: DIGIT_BITS];

    // The leading digit carries the sign; the rest are unsigned.
    always_comb
    begin
        if (ctrl.first_digit)
        begin
            digit_s = {digit_raw[DIGIT_BITS-1], digit_raw};
        end
        else
        begin
            digit_s = {1'b0, digit_raw};
        end
    end

    // Narrow product and Horner step of the per-tap product.
    assign prod = PROD_W'(coef_cur) * PROD_W'(digit_s);

    always_comb
    begin
        if (ctrl.first_digit)
        begin
            tap_next = TAP_W'(prod);
        end
        else
        begin
            tap_next = (tap_acc_reg <<< DIGIT_BITS) + TAP_W'(prod);
        end
    end

    // Digit shift register and per-tap partial product.
    always_ff @(posedge clk)
    begin
        if (ctrl.active)
        begin
            sr_reg      <= sr_src << DIGIT_BITS;
            coef_reg    <= coef_cur;
            tap_acc_reg <= tap_next;
        end
    end

    // A finished tap product is added to the running sum in the cycle after it is finished.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_done_reg <= 1'b0;
        end
        else
        begin
            tap_done_reg <= ctrl.active & ctrl.last_digit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear_acc)
        begin
            acc_reg <= '0;
        end
        else if (tap_done_reg)
        begin
            acc_reg <= acc_reg + ACC_BITS'(tap_acc_reg);
        end
    end

    assign acc = acc_reg;

endmodule

### src/fir_filter_streaming_top.sv
// Top level of the streaming direct-form FIR filter: sequencer, rounding and result register.
// A sample request walks n taps, n being the smaller of tap_count and the samples seen since
// the record start, through the one shared 8-bit digit multiply-accumulate; the sequencer
// steps through S_PREP, S_MAC, S_FLUSH and S_ROUND before the result is registered.
// Throughput: one request at a time; a coefficient write stays in S_IDLE, and a new request
// is taken in the cycle after the previous result is registered, while that result waits.
// Reset clears the sequencer, pointers, fill count and result valid, and sets tap_count to 1.
module fir_filter_streaming_top #(
    parameter int MAX_TAPS       = fir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS    = fir_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = fir_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_wr_en,
    input  logic [fir_pkg::TAP_COUNT_BITS-1:0]         cfg_wr_data,
    input  logic                                       req_valid,
    output logic                                       req_stall,
    input  logic                                       req_type,
    input  logic signed [SAMPLE_BITS-1:0]              sample,
    input  logic                                       block_start,
    input  logic [fir_pkg::COEF_INDEX_BITS-1:0]        coef_index,
    input  logic signed [fir_pkg::COEF_BITS-1:0]       coef_value,
    output logic                                       rsp_valid,
    input  logic                                       rsp_stall,
    output logic signed [SAMPLE_BITS-1:0]              filtered,
    output logic                                       saturated
);
    import fir_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_TAPS);
    localparam int CNT_BITS  = $clog2(MAX_TAPS + 1);
    localparam int NDIG      = digit_count(SAMPLE_BITS);
    localparam int DIG_BITS  = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int ACC_BITS  = COEF_BITS + SAMPLE_BITS + $clog2(MAX_TAPS) + 1;

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_HI = (ACC_BITS'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [ACC_BITS-1:0] SAT_LO = -(ACC_BITS'(1) << (SAMPLE_BITS - 1));

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_MAC   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [TAP_COUNT_BITS-1:0]   tap_count_reg;
    logic [CNT_BITS-1:0]         taps_cl;
    logic [CNT_BITS-1:0]         taps_eff_reg;
    logic [CNT_BITS-1:0]         done_cnt_reg;
    logic [DIG_BITS-1:0]         dig_cnt_reg;
    logic [ADDR_BITS-1:0]        fetch_idx_reg;
    logic [CNT_BITS-1:0]         fill;
    logic                        req_accept;
    logic                        coef_we;
    logic                        samp_we;
    logic                        first_digit;
    logic                        last_digit;
    logic                        last_tap;
    logic                        fetch;
    logic                        out_free;
    mac_ctrl_t                   mac_ctrl;
    logic signed [COEF_BITS-1:0]   coef_rd;
    logic signed [SAMPLE_BITS-1:0] samp_rd;
    logic signed [ACC_BITS-1:0]    acc;
    logic signed [ACC_BITS-1:0]    rnd;
    logic signed [ACC_BITS-1:0]    shifted;
    logic signed [ACC_BITS-1:0]    y_sat;
    logic                          y_clip;
    logic                          rsp_valid_reg;
    logic signed [SAMPLE_BITS-1:0] filtered_reg;
    logic                          saturated_reg;

    // Request handshake and write strobes.
    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid & ~req_stall;
    assign coef_we    = req_accept & (req_type == REQ_COEF) & (32'(coef_index) < MAX_TAPS);
    assign samp_we    = req_accept & (req_type == REQ_SAMPLE);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_COUNT_BITS'(1);
        end
        else if (cfg_wr_en)
        begin
            tap_count_reg <= cfg_wr_data;
        end
    end

    // Tap count limited to the range the store holds.
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            taps_cl = CNT_BITS'(1);
        end
        else if (32'(tap_count_reg) > MAX_TAPS)
        begin
            taps_cl = CNT_BITS'(MAX_TAPS);
        end
        else
        begin
            taps_cl = CNT_BITS'(tap_count_reg);
        end
    end

    // Digit and tap position within the walk.
    assign first_digit = (dig_cnt_reg == '0);
    assign last_digit  = (dig_cnt_reg == DIG_BITS'(NDIG - 1));
    assign last_tap    = ((done_cnt_reg + CNT_BITS'(1)) == taps_eff_reg);
    assign fetch       = (state_reg == S_PREP) ||
                         ((state_reg == S_MAC) && last_digit && !last_tap);
    assign out_free    = ~rsp_valid_reg | ~rsp_stall;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (samp_we)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (last_digit && last_tap)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Tap walk counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_eff_reg  <= CNT_BITS'(1);
            done_cnt_reg  <= '0;
            dig_cnt_reg   <= '0;
            fetch_idx_reg <= '0;
        end
        else
        begin
            if (samp_we)
            begin
                fetch_idx_reg <= '0;
            end
            else if (fetch)
            begin
                fetch_idx_reg <= fetch_idx_reg + ADDR_BITS'(1);
            end
            if (state_reg == S_PREP)
            begin
                taps_eff_reg <= (taps_cl < fill) ? taps_cl : fill;
                done_cnt_reg <= '0;
                dig_cnt_reg  <= '0;
            end
            else if (state_reg == S_MAC)
            begin
                if (last_digit)
                begin
                    dig_cnt_reg  <= '0;
                    done_cnt_reg <= done_cnt_reg + CNT_BITS'(1);
                end
                else
                begin
                    dig_cnt_reg <= dig_cnt_reg + DIG_BITS'(1);
                end
            end
        end
    end

    assign mac_ctrl.active      = (state_reg == S_MAC);
    assign mac_ctrl.first_digit = first_digit;
    assign mac_ctrl.last_digit  = last_digit;
    assign mac_ctrl.clear_acc   = (state_reg == S_PREP);

    fir_coef_mem #(
        .MAX_TAPS  (MAX_TAPS),
        .ADDR_BITS (ADDR_BITS)
    ) u_coef_mem (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (ADDR_BITS'(coef_index)),
        .wr_data (coef_value),
        .rd_en   (fetch),
        .rd_addr (fetch_idx_reg),
        .rd_data (coef_rd)
    );

    fir_hist_line #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS),
        .FILL_BITS   (CNT_BITS)
    ) u_hist_line (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (samp_we),
        .block_start (block_start),
        .wr_data     (sample),
        .rd_en       (fetch),
        .rd_data     (samp_rd),
        .fill        (fill)
    );

    fir_digit_mac #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_digit_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mac_ctrl),
        .coef_rd (coef_rd),
        .samp_rd (samp_rd),
        .acc     (acc)
    );

    // Round half up, drop the fraction bits and clip to the sample range.
    assign rnd     = acc + ROUND_HALF;
    assign shifted = rnd >>> COEF_FRAC_BITS;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            y_sat  = SAT_HI;
            y_clip = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            y_sat  = SAT_LO;
            y_clip = 1'b1;
        end
        else
        begin
            y_sat  = shifted;
            y_clip = 1'b0;
        end
    end

    // Result register: holds a finished result until the receiver takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_ROUND) && out_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_ROUND) && out_free)
        begin
            filtered_reg  <= SAMPLE_BITS'(y_sat);
            saturated_reg <= y_clip;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign filtered  = filtered_reg;
    assign saturated = saturated_reg;

`ifndef SYNTHESIS
    // The tap walk always covers at least one tap and never more than the store holds.
    a_taps_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (taps_eff_reg != '0 && taps_eff_reg <= CNT_BITS'(MAX_TAPS)))
        else $error("tap walk length out of range");

    // The completed-tap count stays below the walk length while taps are processed.
    a_done_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (done_cnt_reg < taps_eff_reg))
        else $error("tap walk overran its length");

    // A new result only appears after the rounding state.
    a_rsp_from_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_ROUND))
        else $error("result raised outside the rounding state");

    // A clipped result sits on one of the range limits.
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && saturated_reg) |->
        (filtered_reg == SAMPLE_BITS'(SAT_HI) || filtered_reg == SAMPLE_BITS'(SAT_LO)))
        else $error("saturated result not at a range limit");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench of the streaming FIR filter against a request-level predictor.
module tb_top;

    import fir_pkg::*;

    localparam int TAPS          = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 200;
    localparam int HOLD_CYCLES   = 400;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic                         kind;
        logic signed [23:0]           smp;
        logic                         bstart;
        logic [COEF_INDEX_BITS-1:0]   idx;
        logic signed [COEF_BITS-1:0]  cval;
    } fir_request_t;

    typedef struct {
        logic signed [23:0] value;
        logic               sat;
    } fir_output_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [TAP_COUNT_BITS-1:0]     cfg_wr_data;
    logic                          req_valid;
    logic                          req_stall;
    logic                          req_type;
    logic signed [23:0]            sample;
    logic                          block_start;
    logic [COEF_INDEX_BITS-1:0]    coef_index;
    logic signed [COEF_BITS-1:0]   coef_value;
    logic                          rsp_valid;
    logic                          rsp_stall;
    logic signed [23:0]            filtered;
    logic                          saturated;

    // Requests waiting to be offered, and filter outputs waiting to arrive.
    fir_request_t pending_requests [$];
    fir_request_t offered_request;
    fir_output_t  expected_outputs [$];
    fir_output_t  next_expected;

    // Predicted state of the filter.
    logic signed [COEF_BITS-1:0]   coef_mem [TAPS];
    logic signed [23:0]            hist_mem [TAPS];
    logic [TAP_COUNT_BITS-1:0]     tap_reg;

    // Taps written so far, as seen by the stimulus generator.
    bit coef_loaded [TAPS];

    int send_idle_pct;
    int recv_stall_pct;
    int pushed_count;
    int accepted_count;
    int error_count;
    int hold_requests;
    int hold_served;
    int hold_left;

    fir_filter_streaming_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .sample      (sample),
        .block_start (block_start),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .filtered    (filtered),
        .saturated   (saturated)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    // Shifts a sample into the predicted history, cleared first at a record start, and works out the filter output.
    function automatic fir_output_t filter_sample(input logic signed [23:0] x,
                                                  input logic clear);
        longint      acc;
        longint      y;
        int          taps;
        fir_output_t r;
        if (clear)
        begin
            for (int k = 0; k < TAPS; k++)
                hist_mem[k] = '0;
        end
        for (int k = TAPS - 1; k > 0; k--)
            hist_mem[k] = hist_mem[k - 1];
        hist_mem[0] = x;
        taps = (tap_reg == 0) ? 1 : ((tap_reg > TAPS) ? TAPS : int'(tap_reg));
        acc = 0;
        for (int k = 0; k < taps; k++)
            acc += longint'(coef_mem[k]) * longint'(hist_mem[k]);
        // Round half up by dropping the sixteen fraction bits, then clip.
        y = (acc + 64'sd32768) >>> 16;
        r.sat = 1'b0;
        if (y > 64'sd8388607)
        begin
            y = 64'sd8388607;
            r.sat = 1'b1;
        end
        else if (y < -64'sd8388608)
        begin
            y = -64'sd8388608;
            r.sat = 1'b1;
        end
        r.value = y[23:0];
        return r;
    endfunction

    // Counts a failure and reports the first few of them.
    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    // Request driver: offers queued requests and folds accepted ones into the prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid      <= 1'b0;
            req_type       <= REQ_SAMPLE;
            sample         <= '0;
            block_start    <= 1'b0;
            coef_index     <= '0;
            coef_value     <= '0;
            accepted_count = 0;
            for (int k = 0; k < TAPS; k++)
                hist_mem[k] = '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                if (offered_request.kind == REQ_COEF)
                    coef_mem[offered_request.idx] = offered_request.cval;
                else
                    expected_outputs.push_back(filter_sample(offered_request.smp,
                                                             offered_request.bstart));
                accepted_count++;
            end
            if (!req_valid || !req_stall)
            begin
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered_request = pending_requests.pop_front();
                    req_valid   <= 1'b1;
                    req_type    <= offered_request.kind;
                    sample      <= offered_request.smp;
                    block_start <= offered_request.bstart;
                    coef_index  <= offered_request.idx;
                    coef_value  <= offered_request.cval;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the receiver, counted in cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left   <= 0;
            hold_served <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    // Output monitor: compares each accepted output with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_outputs.size() == 0)
                begin
                    note_failure($sformatf("unexpected output: filtered %0d saturated %0b",
                                           filtered, saturated));
                end
                else
                begin
                    next_expected = expected_outputs.pop_front();
                    if (filtered !== next_expected.value || saturated !== next_expected.sat)
                        note_failure($sformatf(
                            "mismatch: expected filtered %0d saturated %0b, got %0d %0b",
                            next_expected.value, next_expected.sat, filtered, saturated));
                end
            end
            rsp_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog against a hung run.
    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic signed [23:0] random_sample();
        logic signed [23:0] v;
        case ($urandom_range(3))
            0: v = 24'($urandom());
            1: v = 24'(int'($urandom_range(0, 8191)) - 4096);
            2: v = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
            default: v = $signed(24'($urandom())) >>> 4;
        endcase
        return v;
    endfunction

    function automatic logic signed [COEF_BITS-1:0] random_coef();
        logic signed [COEF_BITS-1:0] v;
        case ($urandom_range(3))
            0: v = COEF_BITS'($urandom());
            1: v = COEF_BITS'(int'($urandom_range(0, 8191)) - 4096);
            2: v = COEF_BITS'(65536 + int'($urandom_range(0, 4095)) - 2048);
            default: v = $urandom_range(1) ? 18'sh1FFFF : 18'sh20000;
        endcase
        return v;
    endfunction

    function automatic int effective_taps(input int v);
        return (v == 0) ? 1 : ((v > TAPS) ? TAPS : v);
    endfunction

    task automatic push_sample(input logic signed [23:0] x, input logic bs);
        fir_request_t r;
        r.kind   = REQ_SAMPLE;
        r.smp    = x;
        r.bstart = bs;
        r.idx    = COEF_INDEX_BITS'($urandom());
        r.cval   = COEF_BITS'($urandom());
        pending_requests.push_back(r);
        pushed_count++;
    endtask

    task automatic push_coef(input int idx, input logic signed [COEF_BITS-1:0] c,
                             input logic bs);
        fir_request_t r;
        r.kind   = REQ_COEF;
        r.smp    = 24'($urandom());
        r.bstart = bs;
        r.idx    = COEF_INDEX_BITS'(idx);
        r.cval   = c;
        pending_requests.push_back(r);
        pushed_count++;
        coef_loaded[idx] = 1'b1;
    endtask

    // Waits until every request is accepted and every output has arrived.
    task automatic wait_drained();
        @(negedge clk);
        while (accepted_count != pushed_count || expected_outputs.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin send_idle_pct = 78; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            IDLE_BOTH:     begin send_idle_pct = 9;  recv_stall_pct = 9;  end
            default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Loads any taps the new count will read, then writes the register while idle.
    task automatic set_tap_count(input int v);
        for (int k = 0; k < effective_taps(v); k++)
        begin
            if (!coef_loaded[k])
                push_coef(k, random_coef(), 1'b0);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= TAP_COUNT_BITS'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tap_reg     = TAP_COUNT_BITS'(v);
        @(negedge clk);
    endtask

    // Reset, directed requests, then phases of random records.
    initial
    begin : stimulus
        int tap_plan  [12];
        int item_plan [12];
        int remaining;
        int rec_len;
        int pick;
        tap_plan  = '{1, 64, 0, 127, 5, 17, 2, 33, 8, 3, 64, 12};
        item_plan = '{100, 40, 60, 40, 120, 100, 120, 80, 120, 120, 40, 100};
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        tap_reg        = 1;
        pushed_count   = 0;
        error_count    = 0;
        hold_requests  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Unity gain on one tap; the block start on the coefficient request is ignored.
        push_coef(0, 18'sh10000, 1'b1);
        push_sample(24'sh7FFFFF, 1'b1);
        push_sample(24'sh800000, 1'b0);
        push_sample(24'sh000000, 1'b0);
        push_sample(-24'sd1, 1'b0);
        push_sample(24'sd1, 1'b0);
        // Largest gains clip both ways.
        push_coef(0, 18'sh1FFFF, 1'b0);
        push_sample(24'sh7FFFFF, 1'b0);
        push_sample(24'sh800000, 1'b0);
        push_coef(0, 18'sh20000, 1'b0);
        push_sample(24'sh800000, 1'b0);
        push_sample(24'sh7FFFFF, 1'b0);
        // Tiny gain shows rounding at exactly one half.
        push_coef(0, 18'sd1, 1'b0);
        push_sample(24'sd32768, 1'b0);
        push_sample(-24'sd32768, 1'b0);
        push_sample(-24'sd32769, 1'b0);
        // A record that starts with fewer samples than the tap count.
        set_tap_count(4);
        push_sample(24'sd100, 1'b1);
        push_sample(24'sd200, 1'b0);
        push_sample(-24'sd300, 1'b0);
        push_sample(24'sd400, 1'b0);
        push_sample(24'sd500, 1'b0);

        for (int p = 0; p < 12; p++)
        begin
            set_idle(idle_mode_t'(p % 4));
            set_tap_count(tap_plan[p]);
            // Once, the receiver holds off while requests keep coming.
            if (p == 4)
                hold_requests++;
            remaining = item_plan[p];
            while (remaining > 0)
            begin
                rec_len = $urandom_range(1, 2 * effective_taps(tap_plan[p]) + 4);
                for (int j = 0; j < rec_len && remaining > 0; j++)
                begin
                    pick = $urandom_range(99);
                    if (pick < 8)
                        push_coef($urandom_range(TAPS - 1), random_coef(),
                                  1'($urandom_range(1)));
                    else if (pick < 12)
                        push_sample(random_sample(), 1'($urandom_range(1)));
                    else
                        push_sample(random_sample(), j == 0);
                    remaining--;
                end
            end
            wait_drained();
        end

        repeat (END_CYCLES) @(negedge clk);
        if (error_count == 0 && expected_outputs.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
